>>> sv/cau_pkg.sv
// shared codes and types of the complex arithmetic unit
`default_nettype none

package cau_pkg;

    localparam int MODE_W = 3;
    localparam int ST_W   = 2;

    localparam logic [MODE_W-1:0] MODE_ADD  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MUL  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DIV  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ABS  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SQRT = 3'd5;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_DIVZ = 2'd1;
    localparam logic [ST_W-1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic add_op;
        logic sub_op;
        logic mul_op;
        logic div_op;
        logic abs_op;
        logic sqrt_op;
    } cau_op_t;

endpackage

`default_nettype wire

>>> sv/cau_front.sv
// request register and operation decode
`default_nettype none

module cau_front import cau_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    localparam int QW = $bits(cau_op_t) + 4 * DATA_WIDTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire logic [MODE_W-1:0]            mode,
    input  wire logic signed [DATA_WIDTH-1:0] a_re,
    input  wire logic signed [DATA_WIDTH-1:0] a_im,
    input  wire logic signed [DATA_WIDTH-1:0] b_re,
    input  wire logic signed [DATA_WIDTH-1:0] b_im,
    input  wire logic                         q_full,
    output logic                              q_push,
    output logic [QW-1:0]                     q_din
);

    cau_op_t         op;
    logic            f_valid_reg;
    logic [QW-1:0]   f_data_reg;

    always_comb
    begin
        op = '0;
        unique case (mode)
            MODE_ADD:  op.add_op  = 1'b1;
            MODE_SUB:  op.sub_op  = 1'b1;
            MODE_MUL:  op.mul_op  = 1'b1;
            MODE_DIV:  op.div_op  = 1'b1;
            MODE_ABS:  op.abs_op  = 1'b1;
            MODE_SQRT: op.sqrt_op = 1'b1;
            default:   op = '0;
        endcase
    end

    assign req_stall = f_valid_reg && q_full;
    assign q_push    = f_valid_reg && !q_full;
    assign q_din     = f_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (!f_valid_reg || !q_full)
        begin
            f_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            f_data_reg <= {op, a_re, a_im, b_re, b_im};
        end
    end

endmodule

`default_nettype wire

>>> sv/cau_queue.sv
// two-entry queue between decode and datapath
`default_nettype none

module cau_queue #(
    parameter int W = 134
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] din,
    output logic              full,
    input  wire logic         pop,
    output logic              valid,
    output logic [W-1:0]      dout
);

    localparam int DEPTH = 2;

    logic [W-1:0] mem_reg [DEPTH];
    logic         wp_reg;
    logic         rp_reg;
    logic [1:0]   cnt_reg;
    logic [1:0]   cnt_next;

    assign valid = cnt_reg != 2'd0;
    assign full  = cnt_reg == 2'(DEPTH);
    assign dout  = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= din;
        end
    end

endmodule

`default_nettype wire

>>> sv/cau_root.sv
// pipelined integer square root, one root bit per stage
`default_nettype none

module cau_root #(
    parameter int IN_W = 64,
    localparam int RW = (IN_W + 1) / 2
) (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic [IN_W-1:0] din,
    output logic [RW-1:0]        root
);

    localparam int PW  = 2 * RW;
    localparam int RMW = RW + 2;

    logic [RMW-1:0] rem_reg [RW];
    logic [RW-1:0]  rt_reg  [RW];
    logic [PW-1:0]  val_reg [RW];
    logic [PW-1:0]  pad;

    function automatic logic [RMW+RW-1:0] step(
        input logic [RMW-1:0] rem,
        input logic [RW-1:0]  rt,
        input logic [1:0]     pair
    );
        logic [RMW+1:0] cand;
        logic [RMW+1:0] trial;
        logic           ge;
        cand  = {rem, pair};
        trial = (RMW + 2)'({rt, 2'b01});
        ge    = cand >= trial;
        return {(ge ? RMW'(cand - trial) : RMW'(cand)), rt[RW-2:0], ge};
    endfunction

    assign pad  = PW'(din);
    assign root = rt_reg[RW-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            {rem_reg[0], rt_reg[0]} <= step(RMW'(0), RW'(0), pad[PW-1:PW-2]);
            val_reg[0] <= pad << 2;
            for (int i = 1; i < RW; i++)
            begin
                {rem_reg[i], rt_reg[i]} <= step(rem_reg[i-1], rt_reg[i-1],
                                                val_reg[i-1][PW-1:PW-2]);
                val_reg[i] <= val_reg[i-1] << 2;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/cau_back.sv
// arithmetic pipeline: products, divide and root stages, saturation
`default_nettype none

module cau_back import cau_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    localparam int QW = $bits(cau_op_t) + 4 * DATA_WIDTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_valid,
    input  wire logic [QW-1:0]                q_data,
    output logic                              q_pop,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output logic signed [DATA_WIDTH-1:0]      res_re,
    output logic signed [DATA_WIDTH-1:0]      res_im,
    output logic [ST_W-1:0]                   status
);

    localparam int DW  = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2 * DW;
    localparam int SW  = 2 * DW + 1;
    localparam int OPW = $bits(cau_op_t);
    localparam int SQW = DW + F;
    localparam int R2  = (SQW + 1) / 2;
    localparam int NV  = 2 + DW + R2;
    localparam int SAW = OPW + 4 + PW + DW + 2 * (DW + 1);
    localparam int SDW = 2 + 2 * DW + ST_W;

    function automatic logic [DW:0] sat_pack(input logic neg, input logic [PW-1:0] mag);
        logic [PW-1:0] lim;
        logic [PW-1:0] m;
        logic          s;
        logic [DW-1:0] v;
        lim = neg ? (PW'(1) << (DW - 1)) : ((PW'(1) << (DW - 1)) - PW'(1));
        s   = mag > lim;
        m   = s ? lim : mag;
        v   = m[DW-1:0];
        return {s, (neg ? -v : v)};
    endfunction

    function automatic logic [PW+2*DW-1:0] div_step(
        input logic [PW-1:0] rem,
        input logic [DW-1:0] low,
        input logic [DW-1:0] q,
        input logic [PW-1:0] d
    );
        logic [PW:0] cand;
        logic        ge;
        cand = {rem, low[DW-1]};
        ge   = cand >= {1'b0, d};
        return {(ge ? PW'(cand - {1'b0, d}) : PW'(cand)), low << 1, q[DW-2:0], ge};
    endfunction

    // handshake and valid pipeline
    logic          en;
    logic [NV-1:0] v_reg;
    logic          ov_reg;

    assign en        = !ov_reg || !rsp_stall;
    assign q_pop     = en && q_valid;
    assign rsp_valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg  <= {v_reg[NV-2:0], q_valid};
            ov_reg <= v_reg[NV-1];
        end
    end

    // products
    cau_op_t              h_op;
    logic signed [DW-1:0] h_ar, h_ai, h_br, h_bi, br_sel, bi_sel;
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg, qb_reg, qi_reg;
    cau_op_t              op1_reg;
    logic signed [DW-1:0] ar1_reg;
    logic                 ain1_reg;
    logic signed [DW:0]   are1_reg, aim1_reg;

    assign {h_op, h_ar, h_ai, h_br, h_bi} = q_data;
    assign br_sel = (h_op.abs_op || h_op.sqrt_op) ? h_ar : h_br;
    assign bi_sel = (h_op.abs_op || h_op.sqrt_op) ? h_ai : h_bi;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg   <= h_ar * br_sel;
            pb_reg   <= h_ai * bi_sel;
            pc_reg   <= h_ar * h_bi;
            pd_reg   <= h_ai * h_br;
            qb_reg   <= h_br * h_br;
            qi_reg   <= h_bi * h_bi;
            op1_reg  <= h_op;
            ar1_reg  <= h_ar;
            ain1_reg <= h_ai[DW-1];
            if (h_op.sub_op)
            begin
                are1_reg <= (DW + 1)'(h_ar) - (DW + 1)'(h_br);
                aim1_reg <= (DW + 1)'(h_ai) - (DW + 1)'(h_bi);
            end
            else
            begin
                are1_reg <= (DW + 1)'(h_ar) + (DW + 1)'(h_br);
                aim1_reg <= (DW + 1)'(h_ai) + (DW + 1)'(h_bi);
            end
        end
    end

    // combine products into sign and magnitude
    logic signed [SW-1:0] s1, s2, s3, s4, xsel, ysel, xabs, yabs;
    logic [PW-1:0]        dsum;
    logic                 xs2_reg, ys2_reg, dz2_reg, ain2_reg;
    logic [PW-1:0]        xm2_reg, ym2_reg, d2_reg;
    cau_op_t              op2_reg;
    logic signed [DW-1:0] ar2_reg;
    logic signed [DW:0]   are2_reg, aim2_reg;

    assign s1   = SW'(pa_reg) + SW'(pb_reg);
    assign s2   = SW'(pa_reg) - SW'(pb_reg);
    assign s3   = SW'(pc_reg) + SW'(pd_reg);
    assign s4   = SW'(pd_reg) - SW'(pc_reg);
    assign xsel = op1_reg.mul_op ? s2 : s1;
    assign ysel = op1_reg.mul_op ? s3 : s4;
    assign xabs = xsel[SW-1] ? -xsel : xsel;
    assign yabs = ysel[SW-1] ? -ysel : ysel;
    assign dsum = $unsigned(qb_reg) + $unsigned(qi_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xs2_reg  <= xsel[SW-1];
            ys2_reg  <= ysel[SW-1];
            xm2_reg  <= xabs[PW-1:0];
            ym2_reg  <= yabs[PW-1:0];
            d2_reg   <= dsum;
            dz2_reg  <= dsum == '0;
            op2_reg  <= op1_reg;
            ar2_reg  <= ar1_reg;
            ain2_reg <= ain1_reg;
            are2_reg <= are1_reg;
            aim2_reg <= aim1_reg;
        end
    end

    // divide lanes and modulus root
    logic [PW+F-1:0] n_full [2];
    logic [DW+F-1:0] n_top  [2];
    logic [DW-1:0]   n_low  [2];
    logic [PW-1:0]   rem_reg [2][DW];
    logic [DW-1:0]   low_reg [2][DW];
    logic [DW-1:0]   qt_reg  [2][DW];
    logic            ovf_reg [2][DW];
    logic [PW-1:0]   dd_reg  [DW];
    logic [SAW-1:0]  sa_reg  [DW];
    logic [DW-1:0]   m_root;

    assign n_full[0] = {xm2_reg, {F{1'b0}}};
    assign n_full[1] = {ym2_reg, {F{1'b0}}};

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            n_top[l] = n_full[l][PW+F-1:DW];
            n_low[l] = n_full[l][DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dd_reg[0] <= d2_reg;
            sa_reg[0] <= {op2_reg, xs2_reg, ys2_reg, dz2_reg, ain2_reg, xm2_reg,
                          ar2_reg, are2_reg, aim2_reg};
            for (int l = 0; l < 2; l++)
            begin
                {rem_reg[l][0], low_reg[l][0], qt_reg[l][0]} <=
                    div_step(PW'(n_top[l]), n_low[l], DW'(0), d2_reg);
                ovf_reg[l][0] <= n_top[l] >= d2_reg;
            end
            for (int i = 1; i < DW; i++)
            begin
                dd_reg[i] <= dd_reg[i-1];
                sa_reg[i] <= sa_reg[i-1];
                for (int l = 0; l < 2; l++)
                begin
                    {rem_reg[l][i], low_reg[l][i], qt_reg[l][i]} <=
                        div_step(rem_reg[l][i-1], low_reg[l][i-1], qt_reg[l][i-1],
                                 dd_reg[i-1]);
                    ovf_reg[l][i] <= ovf_reg[l][i-1];
                end
            end
        end
    end

    // imaginary product magnitude for multiply
    logic [PW-1:0] ym_pipe_reg [DW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ym_pipe_reg[0] <= ym2_reg >> F;
            for (int i = 1; i < DW; i++)
            begin
                ym_pipe_reg[i] <= ym_pipe_reg[i-1];
            end
        end
    end

    cau_root #(
        .IN_W (PW)
    ) u_root_mod (
        .clk  (clk),
        .en   (en),
        .din  (xm2_reg),
        .root (m_root)
    );

    // early results and square root halves
    cau_op_t              opa;
    logic                 xsa, ysa, dza, aina;
    logic [PW-1:0]        xma;
    logic signed [DW-1:0] ara;
    logic signed [DW:0]   area, aima, re_abs, im_abs;
    logic signed [DW+1:0] s_val, t_val;
    logic [SQW-1:0]       s_in, t_in;
    logic [R2-1:0]        root_s, root_t;
    logic                 e_neg_re, e_neg_im;
    logic [PW-1:0]        e_mag_re, e_mag_im;
    logic [DW:0]          e_pre, e_pim;
    logic [DW-1:0]        e_re, e_im;
    logic [ST_W-1:0]      e_st;
    logic [SDW-1:0]       sd_reg [R2];

    assign {opa, xsa, ysa, dza, aina, xma, ara, area, aima} = sa_reg[DW-1];
    assign re_abs = area[DW] ? -area : area;
    assign im_abs = aima[DW] ? -aima : aima;
    assign s_val  = $signed({2'b00, m_root}) + (DW + 2)'(ara);
    assign t_val  = $signed({2'b00, m_root}) - (DW + 2)'(ara);
    assign s_in   = SQW'(s_val[DW:0]) << (F - 1);
    assign t_in   = SQW'(t_val[DW:0]) << (F - 1);

    always_comb
    begin
        e_neg_re = 1'b0;
        e_neg_im = 1'b0;
        e_mag_re = '0;
        e_mag_im = '0;
        if (opa.add_op || opa.sub_op)
        begin
            e_neg_re = area[DW];
            e_neg_im = aima[DW];
            e_mag_re = PW'($unsigned(re_abs));
            e_mag_im = PW'($unsigned(im_abs));
        end
        else if (opa.mul_op)
        begin
            e_neg_re = xsa;
            e_neg_im = ysa;
            e_mag_re = xma >> F;
            e_mag_im = ym_pipe_reg[DW-1];
        end
        else if (opa.div_op)
        begin
            e_neg_re = xsa;
            e_neg_im = ysa;
            e_mag_re = ovf_reg[0][DW-1] ? '1 : PW'(qt_reg[0][DW-1]);
            e_mag_im = ovf_reg[1][DW-1] ? '1 : PW'(qt_reg[1][DW-1]);
        end
        else if (opa.abs_op)
        begin
            e_mag_re = PW'(m_root);
        end
        e_pre = sat_pack(e_neg_re, e_mag_re);
        e_pim = sat_pack(e_neg_im, e_mag_im);
        e_re  = e_pre[DW-1:0];
        e_im  = e_pim[DW-1:0];
        e_st  = (e_pre[DW] || e_pim[DW]) ? ST_SAT : ST_OK;
        if (opa.div_op && dza)
        begin
            e_re = '0;
            e_im = '0;
            e_st = ST_DIVZ;
        end
    end

    cau_root #(
        .IN_W (SQW)
    ) u_root_s (
        .clk  (clk),
        .en   (en),
        .din  (s_in),
        .root (root_s)
    );

    cau_root #(
        .IN_W (SQW)
    ) u_root_t (
        .clk  (clk),
        .en   (en),
        .din  (t_in),
        .root (root_t)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_reg[0] <= {opa.sqrt_op, aina, e_re, e_im, e_st};
            for (int i = 1; i < R2; i++)
            begin
                sd_reg[i] <= sd_reg[i-1];
            end
        end
    end

    // final selection and output register
    logic            d_sqrt, d_ain;
    logic [DW-1:0]   d_re, d_im;
    logic [ST_W-1:0] d_st;
    logic [DW:0]     q_pre, q_pim;
    logic [DW-1:0]   f_re, f_im;
    logic [ST_W-1:0] f_st;
    logic [DW-1:0]   re_reg, im_reg;
    logic [ST_W-1:0] st_reg;

    assign {d_sqrt, d_ain, d_re, d_im, d_st} = sd_reg[R2-1];
    assign q_pre = sat_pack(1'b0, PW'(root_s));
    assign q_pim = sat_pack(d_ain, PW'(root_t));

    always_comb
    begin
        f_re = d_re;
        f_im = d_im;
        f_st = d_st;
        if (d_sqrt)
        begin
            f_re = q_pre[DW-1:0];
            f_im = q_pim[DW-1:0];
            f_st = (q_pre[DW] || q_pim[DW]) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            re_reg <= f_re;
            im_reg <= f_im;
            st_reg <= f_st;
        end
    end

    assign res_re = $signed(re_reg);
    assign res_im = $signed(im_reg);
    assign status = st_reg;

endmodule

`default_nettype wire

>>> sv/complex_arith_unit.sv
// complex arithmetic unit top level
`default_nettype none

// Signed fixed-point complex ALU (DATA_WIDTH bits, FRAC_BITS fraction bits): add,
// subtract, multiply, divide, modulus and principal square root, with saturation and
// a divide-by-zero status. One request is taken every cycle unless req_stall is high,
// and results leave in request order. The delay from request to result is set by the
// bit-per-stage divide and root pipeline followed by the second root stage of the
// square root. A stalled result holds the whole datapath; a two-entry queue behind the
// request register keeps the request side moving meanwhile, until the queue fills.
module complex_arith_unit import cau_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire logic [MODE_W-1:0]            mode,
    input  wire logic signed [DATA_WIDTH-1:0] a_re,
    input  wire logic signed [DATA_WIDTH-1:0] a_im,
    input  wire logic signed [DATA_WIDTH-1:0] b_re,
    input  wire logic signed [DATA_WIDTH-1:0] b_im,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output logic signed [DATA_WIDTH-1:0]      res_re,
    output logic signed [DATA_WIDTH-1:0]      res_im,
    output logic [ST_W-1:0]                   status
);

    localparam int QW = $bits(cau_op_t) + 4 * DATA_WIDTH;
    localparam logic [DATA_WIDTH-1:0] MAX_V = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_V = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    logic          q_full, q_push, q_pop, q_valid;
    logic [QW-1:0] q_din, q_dout;

    cau_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .mode      (mode),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_din     (q_din)
    );

    cau_queue #(
        .W (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .dout  (q_dout)
    );

    cau_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_dout),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .res_re    (res_re),
        .res_im    (res_im),
        .status    (status)
    );

    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_DIVZ |-> res_re == '0 && res_im == '0)
        else $error("divide by zero with nonzero result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status == ST_OK || status == ST_DIVZ || status == ST_SAT)
        else $error("undefined status code");

    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_SAT |->
            $unsigned(res_re) == MAX_V || $unsigned(res_re) == MIN_V ||
            $unsigned(res_im) == MAX_V || $unsigned(res_im) == MIN_V)
        else $error("saturation flagged without a clamped part");

endmodule

`default_nettype wire
